@@ sv/pam_pkg.sv @@
package pam_pkg;

	// image geometry
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CFG_W     = 12;

	localparam logic [CFG_W-1:0] IMG_WIDTH_RESET = 12'd1500;
	localparam logic [CFG_W-1:0] IMG_WIDTH_CAP   = CFG_W'(MAX_WIDTH);

	// frame layout
	localparam logic [15:0] MAC_END        = 16'd12;
	localparam logic [15:0] ETYPE_HI_POS   = 16'd12;
	localparam logic [15:0] ETYPE_LO_POS   = 16'd13;
	localparam logic [15:0] INNER_HI_POS   = 16'd16;
	localparam logic [15:0] INNER_LO_POS   = 16'd17;
	localparam logic [5:0]  NET_START_PLAIN = 6'd14;
	localparam logic [5:0]  NET_START_VLAN  = 6'd18;
	localparam logic [15:0] POS_MAX        = 16'hFFFF;

	// masked ranges inside the network header
	localparam logic [5:0] V4_SRC_FIRST = 6'd12;
	localparam logic [5:0] V4_SRC_LAST  = 6'd15;
	localparam logic [5:0] V6_SRC_FIRST = 6'd8;
	localparam logic [5:0] V6_SRC_LAST  = 6'd23;

	// ethertypes
	localparam logic [15:0] ETH_VLAN = 16'h8100;
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	typedef enum logic [1:0] {
		NET_NONE = 2'd0,
		NET_IPV4 = 2'd1,
		NET_IPV6 = 2'd2
	} net_kind_t;

	// per-frame parse state
	typedef struct packed {
		logic [15:0] pos;
		logic [15:0] etype;
		logic        vlan;
		net_kind_t   kind;
		logic [5:0]  ihl_len;
	} frame_state_t;

	localparam frame_state_t FRAME_RESET = '{
		pos:        16'd0,
		etype:      16'd0,
		vlan:       1'b0,
		kind:       NET_NONE,
		ihl_len:    6'd0
	};

	// classifier result for one word
	typedef struct packed {
		logic         emit;
		logic         show;
		frame_state_t next;
	} verdict_t;

endpackage

@@ sv/pam_in_if.sv @@
interface pam_in_if import pam_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source (output valid, output packet_byte, output last_byte, input ready);
	modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

@@ sv/pam_out_if.sv @@
interface pam_out_if import pam_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column_index;
	logic [7:0]       row_index;
	logic             pixel_set;
	logic             frame_end;

	modport source (output valid, output column_index, output row_index,
		output pixel_set, output frame_end, input ready);
	modport sink (input valid, input column_index, input row_index,
		input pixel_set, input frame_end, output ready);
endinterface

@@ sv/pam_cfg_if.sv @@
interface pam_cfg_if import pam_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] image_width;

	modport source (output valid, output image_width, input ready);
	modport sink (input valid, input image_width, output ready);
endinterface

@@ sv/pam_classify.sv @@
module pam_classify import pam_pkg::*; (
	input  frame_state_t     st,
	input  logic [7:0]       pkt_byte,
	input  logic             last,
	input  logic [CFG_W-1:0] width,
	output verdict_t         vd
);

	logic [15:0]      p;
	logic [5:0]       net_start;
	logic             near;
	logic [5:0]       off;
	logic             in_net;
	logic             at_start;
	net_kind_t        kind_now;
	logic [CFG_W-1:0] limit;
	logic             mask_v4;
	logic             mask_v6;
	frame_state_t     nxt;
	logic             show;

	assign p         = st.pos;
	assign net_start = st.vlan ? NET_START_VLAN : NET_START_PLAIN;
	// offsets that matter are all below 64
	assign near      = (p[15:6] == '0);
	assign off       = p[5:0] - net_start;
	assign in_net    = !near || (p[5:0] >= net_start);
	assign at_start  = near && (p[5:0] == net_start);
	assign limit     = (width > IMG_WIDTH_CAP) ? IMG_WIDTH_CAP : width;

	always_comb begin
		nxt  = st;
		show = 1'b1;

		// ethertype capture, outer then inner behind one tag
		if (p < MAC_END) begin
			show = 1'b0;
		end else if (p == ETYPE_HI_POS) begin
			nxt.etype = {pkt_byte, 8'h00};
		end else if (p == ETYPE_LO_POS) begin
			nxt.etype = {st.etype[15:8], pkt_byte};
			if ({st.etype[15:8], pkt_byte} == ETH_VLAN)
				nxt.vlan = 1'b1;
		end else if (st.vlan && p == INNER_HI_POS) begin
			nxt.etype = {pkt_byte, 8'h00};
		end else if (st.vlan && p == INNER_LO_POS) begin
			nxt.etype = {st.etype[15:8], pkt_byte};
		end

		// protocol decided on the first network header byte
		kind_now = st.kind;
		if (at_start) begin
			if (st.etype == ETH_IPV4) begin
				kind_now    = NET_IPV4;
				nxt.ihl_len = {pkt_byte[3:0], 2'b00};
			end else if (st.etype == ETH_IPV6) begin
				kind_now = NET_IPV6;
			end else begin
				kind_now = NET_NONE;
			end
		end
		nxt.kind = kind_now;

		mask_v4 = in_net && near && (kind_now == NET_IPV4) && (off >= V4_SRC_FIRST)
			&& (off <= V4_SRC_LAST) && (off < st.ihl_len);
		mask_v6 = in_net && near && (kind_now == NET_IPV6) && (off >= V6_SRC_FIRST)
			&& (off <= V6_SRC_LAST);
		if (mask_v4 || mask_v6)
			show = 1'b0;

		if (last)
			nxt = FRAME_RESET;
		else if (p != POS_MAX)
			nxt.pos = p + 16'd1;

		vd.emit = (p < {4'b0000, limit});
		vd.show = show;
		vd.next = nxt;
	end

endmodule

@@ sv/packet_address_masking_onehot.sv @@
// frame bytes to one-hot image columns with address bytes blanked. each
// accepted word is one frame byte; it lands in an input register, is
// classified combinationally against the per-frame parse state (MAC addresses,
// ethertype with one VLAN tag skipped, IPv4 or IPv6 source address), and the
// result goes to an output register. a new byte is taken every cycle as
// long as the result side keeps up: throughput is one byte per cycle,
// with the classify step lying between the input and output registers.
// bytes at positions at or beyond image_width (capped at 2048) make no
// result but still advance the parse state, and a last_byte mark on them
// still closes the frame. image_width is written through the cfg channel,
// which is always ready; write it only while no byte is in flight. there
// is no clearing pass after reset.
module packet_address_masking_onehot import pam_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pam_in_if.sink     pkt,
	pam_out_if.source  res,
	pam_cfg_if.sink    cfg
);

	// configuration
	logic [CFG_W-1:0] width_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-frame parse state
	frame_state_t state_q;
	verdict_t     vd;

	// output register
	logic             res_valid_q;
	logic [COL_W-1:0] col_q;
	logic [7:0]       row_q;
	logic             pix_q;
	logic             end_q;

	logic res_free;
	logic adv_s1;
	logic pkt_take;

	// output register can load when empty or being drained this cycle
	assign res_free = !res_valid_q || res.ready;
	// a dropped byte moves on without needing the output register
	assign adv_s1   = valid_s1 && (!vd.emit || res_free);
	assign pkt.ready = !valid_s1 || adv_s1;
	assign pkt_take = pkt.valid && pkt.ready;
	assign cfg.ready = 1'b1;

	pam_classify u_classify (
		.st       (state_q),
		.pkt_byte (byte_s1),
		.last     (last_s1),
		.width    (width_q),
		.vd       (vd)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMG_WIDTH_RESET;
		end else if (cfg.valid) begin
			width_q <= cfg.image_width;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			byte_s1 <= pkt.packet_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	// parse state advances once per classified byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAME_RESET;
		end else if (adv_s1) begin
			state_q <= vd.next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && vd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vd.emit) begin
			col_q <= state_q.pos[COL_W-1:0];
			// 255 minus the byte, blank column reads zero
			row_q <= vd.show ? ~byte_s1 : 8'd0;
			pix_q <= vd.show;
			end_q <= last_s1;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.column_index = col_q;
	assign res.row_index    = row_q;
	assign res.pixel_set    = pix_q;
	assign res.frame_end    = end_q;

	// a blanked column never carries a row
	a_blank_row: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !pix_q) |-> (row_q == 8'd0))
		else $error("blank column with nonzero row");

	// MAC address columns are always blanked
	a_mac_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (col_q < COL_W'(MAC_END))) |-> !pix_q)
		else $error("MAC address byte shown");

	// the byte after a frame end starts at position zero
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (state_q.pos == 16'd0))
		else $error("position not cleared after frame end");

	// an empty input stage never stalls the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pkt.ready)
		else $error("input stalled with empty stage");

endmodule

@@ tb/packet_address_masking_onehot_tb.sv @@
`timescale 1ns / 100ps

module packet_address_masking_onehot_tb;
	import pam_pkg::*;

	// idle cycles with no handshake on any channel before the run is called hung
	localparam int IDLE_LIMIT = 2000;
	// random items per width setting
	localparam int PHASE_ITEMS = 250;

	// one expected image column
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [7:0]       row;
		logic             pix;
		logic             fe;
	} pixel_t;

	// one directed word, with its column typed in where it is obvious
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       typed;
		pixel_t     exp;
	} stim_row_t;

	// directed table: ipv6 frame with mac extremes, then one-word frames and a
	// frame ending inside the mac addresses
	localparam stim_row_t DIR_ROWS [24] = '{
		'{8'h00, 1'b0, 1'b1, '{11'd0,  8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{11'd1,  8'h00, 1'b0, 1'b0}},
		'{8'h01, 1'b0, 1'b1, '{11'd2,  8'h00, 1'b0, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{11'd3,  8'h00, 1'b0, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{11'd4,  8'h00, 1'b0, 1'b0}},
		'{8'hFE, 1'b0, 1'b1, '{11'd5,  8'h00, 1'b0, 1'b0}},
		'{8'h55, 1'b0, 1'b1, '{11'd6,  8'h00, 1'b0, 1'b0}},
		'{8'hAA, 1'b0, 1'b1, '{11'd7,  8'h00, 1'b0, 1'b0}},
		'{8'h0F, 1'b0, 1'b1, '{11'd8,  8'h00, 1'b0, 1'b0}},
		'{8'hF0, 1'b0, 1'b1, '{11'd9,  8'h00, 1'b0, 1'b0}},
		'{8'h12, 1'b0, 1'b1, '{11'd10, 8'h00, 1'b0, 1'b0}},
		'{8'h34, 1'b0, 1'b1, '{11'd11, 8'h00, 1'b0, 1'b0}},
		'{8'h86, 1'b0, 1'b1, '{11'd12, 8'h79, 1'b1, 1'b0}},
		'{8'hDD, 1'b0, 1'b1, '{11'd13, 8'h22, 1'b1, 1'b0}},
		'{8'h60, 1'b0, 1'b0, '{11'd0,  8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 1'b0, '{11'd0,  8'h00, 1'b0, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{11'd0,  8'h00, 1'b0, 1'b1}},
		'{8'hFF, 1'b0, 1'b1, '{11'd0,  8'h00, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 1'b1, '{11'd1,  8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{11'd2,  8'h00, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 1'b1, '{11'd3,  8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{11'd4,  8'h00, 1'b0, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{11'd5,  8'h00, 1'b0, 1'b1}},
		'{8'hFF, 1'b1, 1'b1, '{11'd0,  8'h00, 1'b0, 1'b1}}
	};

	logic clk;
	logic arst_n;

	pam_in_if  pkt_if ();
	pam_out_if res_if ();
	pam_cfg_if cfg_if ();

	packet_address_masking_onehot u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// side band that travels with each word: a typed expectation overrides the model
	logic   word_typed;
	pixel_t word_exp;

	// columns still owed by the block, oldest first
	pixel_t pixel_q [$];

	// mirror of the block's parse state and width register
	logic [15:0] pos_m;
	logic [15:0] etype_m;
	logic        vlan_m;
	net_kind_t   kind_m;
	logic [5:0]  ihl_m;
	logic [11:0] width_m;

	int  err_cnt;
	int  idle_cycles;
	int  sent_items;
	bit  gaps_on;
	int  res_stall;

	logic [7:0] frame_bytes [$];

	// monitor scratch
	logic   col_emit;
	pixel_t col_pred;
	pixel_t col_want;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly back to back, sometimes a short gap, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void clear_frame_state();
		pos_m   = '0;
		etype_m = '0;
		vlan_m  = 1'b0;
		kind_m  = NET_NONE;
		ihl_m   = '0;
	endfunction

	// classify one frame byte against the mirrored parse state and advance it
	task automatic classify_byte(input logic [7:0] b, input logic last,
		output logic emit, output pixel_t px);
		logic [15:0] p;
		logic [15:0] net_at;
		logic [15:0] off;
		logic [11:0] lim;
		logic        show;
		p    = pos_m;
		show = 1'b1;
		lim  = (width_m > 12'd2048) ? 12'd2048 : width_m;

		// mac addresses are blanked, ethertype bytes get captured
		if (p < 16'd12)
			show = 1'b0;
		else if (p == 16'd12)
			etype_m = {b, 8'h00};
		else if (p == 16'd13) begin
			etype_m = {etype_m[15:8], b};
			if (etype_m == ETH_VLAN)
				vlan_m = 1'b1;
		end else if (vlan_m && p == 16'd16)
			etype_m = {b, 8'h00};
		else if (vlan_m && p == 16'd17)
			etype_m = {etype_m[15:8], b};

		net_at = vlan_m ? 16'd18 : 16'd14;
		if (p >= net_at) begin
			off = p - net_at;
			// first network header byte decides the protocol, ihl comes with it
			if (off == 16'd0) begin
				if (etype_m == ETH_IPV4) begin
					kind_m = NET_IPV4;
					ihl_m  = {b[3:0], 2'b00};
				end else if (etype_m == ETH_IPV6)
					kind_m = NET_IPV6;
				else
					kind_m = NET_NONE;
			end
			// ipv4 source address only counts while inside the header length
			if (kind_m == NET_IPV4 && off >= 16'd12 && off <= 16'd15 && off < {10'd0, ihl_m})
				show = 1'b0;
			if (kind_m == NET_IPV6 && off >= 16'd8 && off <= 16'd23)
				show = 1'b0;
		end

		emit      = (p < {4'd0, lim});
		px.column = p[COL_W-1:0];
		px.row    = show ? ~b : 8'h00;
		px.pix    = show;
		px.fe     = last;

		// saturating position, everything but the width clears at frame end
		if (last)
			clear_frame_state();
		else if (pos_m != 16'hFFFF)
			pos_m = pos_m + 16'd1;
	endtask

	// monitor: checks results first, then predicts, so a word accepted in the
	// same cycle as a result can never satisfy it
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_frame_state();
			width_m     = IMG_WIDTH_RESET;
			idle_cycles = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (pixel_q.size() == 0) begin
					$error("column %0d arrived with nothing expected", res_if.column_index);
					err_cnt++;
				end else begin
					col_want = pixel_q.pop_front();
					if (res_if.column_index !== col_want.column) begin
						$error("column_index: expected %0d, got %0d",
							col_want.column, res_if.column_index);
						err_cnt++;
					end
					if (res_if.row_index !== col_want.row) begin
						$error("row_index: expected %0d, got %0d", col_want.row, res_if.row_index);
						err_cnt++;
					end
					if (res_if.pixel_set !== col_want.pix) begin
						$error("pixel_set: expected %0d, got %0d", col_want.pix, res_if.pixel_set);
						err_cnt++;
					end
					if (res_if.frame_end !== col_want.fe) begin
						$error("frame_end: expected %0d, got %0d", col_want.fe, res_if.frame_end);
						err_cnt++;
					end
				end
			end

			if (pkt_if.valid && pkt_if.ready) begin
				classify_byte(pkt_if.packet_byte, pkt_if.last_byte, col_emit, col_pred);
				if (word_typed)
					pixel_q.push_back(word_exp);
				else if (col_emit)
					pixel_q.push_back(col_pred);
			end

			if (cfg_if.valid && cfg_if.ready)
				width_m = cfg_if.image_width;

			// watchdog on cycles where nothing moves at all
			if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side back pressure
	always @(posedge clk) begin
		if (!gaps_on)
			res_if.ready <= 1'b1;
		else if (res_stall > 0) begin
			res_if.ready <= 1'b0;
			res_stall--;
		end else begin
			res_if.ready <= 1'b1;
			res_stall = pick_gap();
		end
	end

	// present one word, with an optional gap ahead of it, and wait for acceptance
	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
		input pixel_t exp);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			pkt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_if.valid       <= 1'b1;
		pkt_if.packet_byte <= b;
		pkt_if.last_byte   <= last;
		word_typed         <= typed;
		word_exp           <= exp;
		@(posedge clk);
		while (!pkt_if.ready) @(posedge clk);
		sent_items++;
	endtask

	// hold the sender until every owed column is in, plus the pipeline depth
	// for trailing words that make no column
	task automatic wait_idle();
		pkt_if.valid <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_width(input logic [11:0] w);
		cfg_if.valid       <= 1'b1;
		cfg_if.image_width <= w;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// random frame: mostly well formed ip frames with random content, some
	// truncated ones, some with odd ethertypes, and some plain noise
	task automatic build_frame(input int len_req);
		int kind;
		int len;
		int net_at;
		int i;
		logic [7:0] ihl_byte;
		kind = $urandom_range(0, 99);
		if (len_req > 0)
			len = len_req;
		else if (kind >= 90)
			len = $urandom_range(1, 30);
		else begin
			i = $urandom_range(0, 9);
			len = (i < 8) ? $urandom_range(14, 90) : (i == 8) ? $urandom_range(1, 13)
				: $urandom_range(91, 300);
		end

		frame_bytes.delete();
		for (i = 0; i < len; i++)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		if (kind >= 90)
			return;

		net_at = 14;
		if (kind >= 40 && kind < 72) begin
			// one vlan tag, then the inner ethertype
			net_at = 18;
			if (len > 12) frame_bytes[12] = ETH_VLAN[15:8];
			if (len > 13) frame_bytes[13] = ETH_VLAN[7:0];
		end

		if (kind < 20 || (kind >= 40 && kind < 50)) begin
			if (len > net_at - 2) frame_bytes[net_at-2] = ETH_IPV4[15:8];
			if (len > net_at - 1) frame_bytes[net_at-1] = ETH_IPV4[7:0];
			// usually a 20 byte header, sometimes any ihl including short ones
			ihl_byte = ($urandom_range(0, 9) < 7) ? 8'h45 : {4'h4, 4'($urandom_range(0, 15))};
			if (len > net_at) frame_bytes[net_at] = ihl_byte;
		end else if (kind < 40 || (kind >= 50 && kind < 60)) begin
			if (len > net_at - 2) frame_bytes[net_at-2] = ETH_IPV6[15:8];
			if (len > net_at - 1) frame_bytes[net_at-1] = ETH_IPV6[7:0];
			if (len > net_at) frame_bytes[net_at] = {4'h6, 4'($urandom_range(0, 15))};
		end else if (kind >= 60 && kind < 65) begin
			// nested tag: only the outer one is skipped
			if (len > 16) frame_bytes[16] = ETH_VLAN[15:8];
			if (len > 17) frame_bytes[17] = ETH_VLAN[7:0];
		end
	endtask

	task automatic send_frame(input int len_req, input bit hold);
		int hold_at;
		int i;
		pixel_t none;
		none = '0;
		build_frame(len_req);
		hold_at = hold ? $urandom_range(0, frame_bytes.size() - 1) : -1;
		for (i = 0; i < frame_bytes.size(); i++) begin
			if (i == hold_at)
				wait_idle();
			send_byte(frame_bytes[i], (i == frame_bytes.size() - 1), 1'b0, none);
		end
	endtask

	initial begin
		logic [11:0] widths [8];
		int ph;
		int i;
		int phase_end;
		bit first;

		clk                = 1'b0;
		arst_n             = 1'b0;
		pkt_if.valid       = 1'b0;
		pkt_if.packet_byte = '0;
		pkt_if.last_byte   = 1'b0;
		res_if.ready       = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.image_width = '0;
		word_typed         = 1'b0;
		word_exp           = '0;
		err_cnt            = 0;
		sent_items         = 0;
		gaps_on            = 1'b1;
		res_stall          = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset width; hold the sender once mid frame
		for (i = 0; i < $size(DIR_ROWS); i++) begin
			send_byte(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].exp);
			if (i == 13)
				wait_idle();
		end
		wait_idle();

		// width settings: above the cap, one column, zero, then assorted
		widths[0] = 12'hFFF;
		widths[1] = 12'd1;
		widths[2] = 12'd0;
		widths[3] = 12'd64;
		widths[4] = 12'd2048;
		widths[5] = 12'd2047;
		widths[6] = 12'd13;
		widths[7] = 12'($urandom_range(1, 2048));

		first = 1'b1;
		for (ph = 0; ph < 8; ph++) begin
			write_width(widths[ph]);
			// one setting runs with no idling on either side
			gaps_on = (ph != 3);
			if (widths[ph] == 12'd0)
				repeat (3) send_frame(0, 1'b0);
			else begin
				phase_end = sent_items + PHASE_ITEMS;
				while (sent_items < phase_end) begin
					send_frame(0, first || ($urandom_range(0, 39) == 0));
					first = 1'b0;
				end
			end
			wait_idle();
		end

		gaps_on = 1'b1;
		write_width(IMG_WIDTH_RESET);
		repeat (3) send_frame(0, 1'b0);
		wait_idle();
		repeat (8) @(posedge clk);

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
sv/pam_pkg.sv
sv/pam_in_if.sv
sv/pam_out_if.sv
sv/pam_cfg_if.sv
sv/pam_classify.sv
sv/packet_address_masking_onehot.sv
tb/packet_address_masking_onehot_tb.sv
